// File: sv/bfha_pkg.sv
// Package: shared constants, codes, types and helpers of the best-fit hole allocator.
`default_nettype none
package bfha_pkg;

  localparam int MAX_HOLES = 16;
  localparam int HIDX_W    = $clog2(MAX_HOLES);
  localparam int CNT_W     = $clog2(MAX_HOLES + 1);
  localparam int SIZE_W    = 16;
  localparam int HCNT_W    = 5;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam logic [HCNT_W-1:0] HCNT_RESET = 5'd16;

  // register index taken from paddr[2]
  localparam logic REG_HOLE_COUNT = 1'b0;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_ALLOCATED = 2'd1;
  localparam logic [1:0] ST_NO_FIT    = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic              en;
    logic [HIDX_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              taken;
  } tbl_wr_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              taken;
  } tbl_rd_t;

  // entries in use: register value saturated to the table depth
  function automatic logic [CNT_W-1:0] holes_in_use(input logic [HCNT_W-1:0] hc);
    int unsigned v;
    v = 32'(hc);
    if (v > MAX_HOLES) v = MAX_HOLES;
    return CNT_W'(v);
  endfunction

endpackage
`default_nettype wire

// File: sv/bfha_if.sv
// Interfaces: input and result channels of the best-fit hole allocator.
`default_nettype none
interface bfha_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  hole_index;
  logic [15:0] amount;
  modport source (output valid, output kind, output hole_index, output amount, input ready);
  modport sink   (input valid, input kind, input hole_index, input amount, output ready);
endinterface

interface bfha_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  chosen_hole;
  logic [15:0] remaining_size;
  modport source (output valid, output status, output chosen_hole, output remaining_size,
                  input ready);
  modport sink   (input valid, input status, input chosen_hole, input remaining_size,
                  output ready);
endinterface
`default_nettype wire

// File: sv/best_fit_hole_allocator.sv
// Top level: best-fit hole allocator (config port, hole table, scan sequencer).
//
// Usage notes
//  - in_ch carries one word per item: kind (0 load, 1 request), hole_index, amount.
//    A word is taken at a clock edge with in_ch.valid and in_ch.ready high.
//  - out_ch carries one result word per item: status, chosen_hole, remaining_size.
//  - cfg_* is an APB-style port; hole_count lives at byte address 0. pready is tied
//    high; write it only while no item is in flight.
//  - A load's result word goes from acceptance through S_FIN into the output
//    register; a request first scans the n holes in use (hole_count saturated
//    to the table depth). The scan reads one table entry per cycle through the
//    single read port and runs it through the one fit/compare unit.
//  - in_ch.ready is high only while the sequencer is idle, one item at a time; the
//    next word is taken only after the last item has posted its result in S_FIN.
//  - The result sits in an output register, so the next word is accepted while
//    a finished result still waits. If the receiver stalls and the next item
//    finishes, the sequencer holds that result until the register frees.
//  - Reset (rst_n low, synchronous): every hole zero-sized and free, hole_count 16,
//    no result pending.
`default_nettype none
module best_fit_hole_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bfha_in_if.sink                          in_ch,
  bfha_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [bfha_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [bfha_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [bfha_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  logic [bfha_pkg::CNT_W-1:0]  n_use;   // holes taking part
  bfha_pkg::tbl_wr_t           tbl_wr;  // table write from the final step
  bfha_pkg::tbl_rd_t           tbl_rd;  // entry under the scan pointer
  logic [bfha_pkg::HIDX_W-1:0] rd_addr;

  // configuration register
  bfha_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .n_use   (n_use)
  );

  // hole sizes and taken flags, cleared at reset
  bfha_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd      (tbl_rd)
  );

  // sequencer: accept, scan one hole per cycle, update table, post result
  bfha_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .n_use   (n_use),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd      (tbl_rd)
  );

endmodule
`default_nettype wire

// File: sv/bfha_cfg.sv
// Module: APB-style configuration register (hole count).
`default_nettype none
module bfha_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bfha_pkg::CFG_AW-1:0] paddr,
  input  wire logic [bfha_pkg::CFG_DW-1:0] pwdata,
  output logic      [bfha_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output logic      [bfha_pkg::CNT_W-1:0]  n_use
);

  logic [bfha_pkg::HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic                        hit;

  assign hit    = (paddr[2] == bfha_pkg::REG_HOLE_COUNT);
  assign pready = 1'b1;

  always_comb begin
    hcnt_nxt = hcnt_r;
    if (psel && penable && pwrite && hit) hcnt_nxt = pwdata[bfha_pkg::HCNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= bfha_pkg::HCNT_RESET;
    end else begin
      hcnt_r <= hcnt_nxt;
    end
  end

  assign prdata = hit ? bfha_pkg::CFG_DW'(hcnt_r) : '0;
  assign n_use  = bfha_pkg::holes_in_use(hcnt_r);

endmodule
`default_nettype wire

// File: sv/bfha_table.sv
// Module: hole table, one read port for the scan and one write port.
`default_nettype none
module bfha_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bfha_pkg::tbl_wr_t           wr,
  input  wire logic [bfha_pkg::HIDX_W-1:0] rd_addr,
  output bfha_pkg::tbl_rd_t                rd
);

  logic [bfha_pkg::SIZE_W-1:0] size_r  [bfha_pkg::MAX_HOLES];
  logic                        taken_r [bfha_pkg::MAX_HOLES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bfha_pkg::MAX_HOLES; i++) begin
        size_r[i]  <= '0;
        taken_r[i] <= 1'b0;
      end
    end else if (wr.en) begin
      size_r[wr.addr]  <= wr.size;
      taken_r[wr.addr] <= wr.taken;
    end
  end

  assign rd.size  = size_r[rd_addr];
  assign rd.taken = taken_r[rd_addr];

endmodule
`default_nettype wire

// File: sv/bfha_seq.sv
// Module: sequencer, shared fit/compare unit and result register.
`default_nettype none
module bfha_seq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bfha_pkg::CNT_W-1:0] n_use,
  bfha_in_if.sink                         in_ch,
  bfha_out_if.source                      out_ch,
  output bfha_pkg::tbl_wr_t               wr,
  output logic [bfha_pkg::HIDX_W-1:0]     rd_addr,
  input  wire bfha_pkg::tbl_rd_t          rd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         kind_r, kind_nxt;
  logic [3:0]                   idx_r, idx_nxt;
  logic [bfha_pkg::SIZE_W-1:0]  amt_r, amt_nxt;
  logic [bfha_pkg::HIDX_W-1:0]  ptr_r, ptr_nxt;
  logic                         found_r, found_nxt;
  logic [bfha_pkg::HIDX_W-1:0]  best_r, best_nxt;
  logic [bfha_pkg::SIZE_W-1:0]  bsize_r, bsize_nxt;
  logic                         ovld_r, ovld_nxt;
  logic [1:0]                   ost_r, ost_nxt;
  logic [3:0]                   ohole_r, ohole_nxt;
  logic [15:0]                  orem_r, orem_nxt;

  logic accept, fit, better, last, fin_go, load_ok;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_addr     = ptr_r;

  // shared compare unit: fit test and best-so-far test on the entry under the pointer
  assign fit    = !rd.taken && (rd.size >= amt_r);
  assign better = !found_r || (rd.size < bsize_r);
  assign last   = (bfha_pkg::CNT_W'(ptr_r) + bfha_pkg::CNT_W'(1)) == n_use;

  assign fin_go  = (state_r == S_FIN) && (!ovld_r || out_ch.ready);
  assign load_ok = (32'(idx_r) < 32'(n_use));

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    amt_nxt   = amt_r;
    ptr_nxt   = ptr_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    bsize_nxt = bsize_r;
    ovld_nxt  = ovld_r;
    ost_nxt   = ost_r;
    ohole_nxt = ohole_r;
    orem_nxt  = orem_r;
    wr        = '0;

    if (ovld_r && out_ch.ready) ovld_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_ch.kind;
          idx_nxt   = in_ch.hole_index;
          amt_nxt   = in_ch.amount;
          ptr_nxt   = '0;
          found_nxt = 1'b0;
          best_nxt  = '0;
          bsize_nxt = '0;
          if (in_ch.kind == bfha_pkg::KIND_REQ && n_use != '0) state_nxt = S_SCAN;
          else state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (fit && better) begin
          found_nxt = 1'b1;
          best_nxt  = ptr_r;
          bsize_nxt = rd.size;
        end
        if (last) state_nxt = S_FIN;
        else ptr_nxt = ptr_r + bfha_pkg::HIDX_W'(1);
      end
      S_FIN: begin
        if (fin_go) begin
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
          if (kind_r == bfha_pkg::KIND_LOAD) begin
            if (load_ok) begin
              wr.en     = 1'b1;
              wr.addr   = bfha_pkg::HIDX_W'(idx_r);
              wr.size   = amt_r;
              wr.taken  = 1'b0;
              ost_nxt   = bfha_pkg::ST_LOADED;
              ohole_nxt = idx_r;
              orem_nxt  = amt_r;
            end else begin
              ost_nxt   = bfha_pkg::ST_BAD_INDEX;
              ohole_nxt = '0;
              orem_nxt  = '0;
            end
          end else if (found_r) begin
            wr.en     = 1'b1;
            wr.addr   = best_r;
            wr.size   = bsize_r - amt_r;
            wr.taken  = 1'b1;
            ost_nxt   = bfha_pkg::ST_ALLOCATED;
            ohole_nxt = 4'(best_r);
            orem_nxt  = bsize_r - amt_r;
          end else begin
            ost_nxt   = bfha_pkg::ST_NO_FIT;
            ohole_nxt = '0;
            orem_nxt  = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
      found_r <= 1'b0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      found_r <= found_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    idx_r   <= idx_nxt;
    amt_r   <= amt_nxt;
    best_r  <= best_nxt;
    bsize_r <= bsize_nxt;
    ost_r   <= ost_nxt;
    ohole_r <= ohole_nxt;
    orem_r  <= orem_nxt;
  end

  assign out_ch.valid          = ovld_r;
  assign out_ch.status         = ost_r;
  assign out_ch.chosen_hole    = ohole_r;
  assign out_ch.remaining_size = orem_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted word did not start the sequencer");

  a_null_fields: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && (ost_r == bfha_pkg::ST_NO_FIT || ost_r == bfha_pkg::ST_BAD_INDEX)
    |-> ohole_r == '0 && orem_r == '0)
    else $error("failed result carries a hole or size");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> bfha_pkg::CNT_W'(ptr_r) < n_use)
    else $error("scan pointer beyond holes in use");

  a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && kind_r == bfha_pkg::KIND_REQ && found_r |-> bsize_r >= amt_r)
    else $error("chosen hole smaller than request");

endmodule
`default_nettype wire

// File: tb/tb_best_fit_hole_allocator.sv
// Self-checking regression for the best-fit hole allocator: directed cases, then random traffic.
module tb_best_fit_hole_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no word moving on any port before the run is declared hung.
  // The slowest legal gap is a full-table scan plus sender gaps,
  // receiver stalls and a register write, so this is many times over.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles left to run once nothing is outstanding, to catch stray results.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [bfha_pkg::CFG_AW-1:0] HOLE_COUNT_ADDR =
    bfha_pkg::CFG_AW'(4 * bfha_pkg::REG_HOLE_COUNT);

  typedef struct packed {
    logic                        kind;
    logic [3:0]                  hole_index;
    logic [bfha_pkg::SIZE_W-1:0] amount;
  } hole_op_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [3:0]                  chosen_hole;
    logic [bfha_pkg::SIZE_W-1:0] remaining_size;
  } hole_outcome_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [bfha_pkg::CFG_AW-1:0] cfg_paddr;
  logic [bfha_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [bfha_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  bfha_in_if  in_ch ();
  bfha_out_if out_ch ();

  best_fit_hole_allocator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow of the hole table and of hole_count, kept in step with every
  // accepted word.
  logic [bfha_pkg::SIZE_W-1:0] hole_size_mirror  [bfha_pkg::MAX_HOLES];
  logic                        hole_taken_mirror [bfha_pkg::MAX_HOLES];
  logic [bfha_pkg::HCNT_W-1:0] hole_count_mirror;

  // Outcomes still owed by the block, oldest first.
  hole_outcome_t due_outcomes [$];

  int unsigned mismatch_count;
  bit          send_gaps;
  bit          recv_stalls;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // hole_count clipped to the table depth; values above it use the whole table.
  function automatic int unsigned live_holes();
    return (hole_count_mirror > bfha_pkg::MAX_HOLES) ? bfha_pkg::MAX_HOLES
                                                     : int'(hole_count_mirror);
  endfunction

  // Applies one word to the shadow table and returns what the block must report.
  function automatic hole_outcome_t best_fit_outcome(input hole_op_t op);
    hole_outcome_t res;
    int unsigned   live;
    int            best;
    int            j;
    res  = '0;
    live = live_holes();
    best = -1;
    if (op.kind == bfha_pkg::KIND_LOAD) begin
      if (op.hole_index >= live) begin
        // index outside the holes in use: table untouched, hole and size zero
        res.status = bfha_pkg::ST_BAD_INDEX;
      end else begin
        hole_size_mirror[op.hole_index]  = op.amount;
        hole_taken_mirror[op.hole_index] = 1'b0;
        res.status         = bfha_pkg::ST_LOADED;
        res.chosen_hole    = op.hole_index;
        res.remaining_size = op.amount;
      end
    end else begin
      // smallest free hole that fits; strict less keeps the lowest index on a tie
      for (j = 0; j < int'(live); j++) begin
        if (!hole_taken_mirror[j] && hole_size_mirror[j] >= op.amount &&
            (best < 0 || hole_size_mirror[j] < hole_size_mirror[best])) begin
          best = j;
        end
      end
      if (best < 0) begin
        res.status = bfha_pkg::ST_NO_FIT;
      end else begin
        hole_size_mirror[best]  = hole_size_mirror[best] - op.amount;
        hole_taken_mirror[best] = 1'b1;
        res.status         = bfha_pkg::ST_ALLOCATED;
        res.chosen_hole    = 4'(best);
        res.remaining_size = hole_size_mirror[best];
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offers one word and returns in the step it is taken. valid is left high so
  // that a following word can go out in the very next cycle.
  task automatic send_word(input logic kind, input logic [3:0] idx,
                           input logic [bfha_pkg::SIZE_W-1:0] amount);
    hole_op_t op;
    op.kind       = kind;
    op.hole_index = idx;
    op.amount     = amount;
    if (send_gaps) begin
      while ($urandom_range(99) < 19) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= op.kind;
    in_ch.hole_index <= op.hole_index;
    in_ch.amount     <= op.amount;
    do @(posedge clk); while (!in_ch.ready);
    due_outcomes.push_back(best_fit_outcome(op));
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic wait_drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_outcomes.size() != 0);
  endtask

  // Writes hole_count through the APB port once the block is idle, then reads
  // it back. Every word yields a result, so an empty queue means idle.
  task automatic write_hole_count(input logic [bfha_pkg::HCNT_W-1:0] count);
    wait_drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= HOLE_COUNT_ADDR;
    cfg_pwdata  <= bfha_pkg::CFG_DW'(count);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    hole_count_mirror = count;
    // read-back: setup, then access
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== bfha_pkg::CFG_DW'(count)) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("hole_count read-back: expected %0d got %0d", count, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  // Load sizes lean small so that ties and exact fits come up often.
  function automatic logic [bfha_pkg::SIZE_W-1:0] load_amount();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return bfha_pkg::SIZE_W'($urandom);
      default: return bfha_pkg::SIZE_W'($urandom_range(63));
    endcase
  endfunction

  // Requests are mostly aimed at a size already in the table: exact fit, a bit
  // under, one over; the rest are extremes and noise.
  function automatic logic [bfha_pkg::SIZE_W-1:0] request_amount();
    logic [bfha_pkg::SIZE_W-1:0] base;
    base = hole_size_mirror[$urandom_range(bfha_pkg::MAX_HOLES - 1)];
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return bfha_pkg::SIZE_W'($urandom);
      4, 5:    return base;
      6, 7:    return (base > 20) ? base - bfha_pkg::SIZE_W'($urandom_range(20))
                                  : bfha_pkg::SIZE_W'($urandom_range(20));
      default: return base + 1'b1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full table: empty-table requests, extremes of size, ties and exhaustion.
  task automatic test_directed_fit();
    send_word(bfha_pkg::KIND_REQ,  4'h0, 16'h0000);  // zero request takes a zero-sized hole
    send_word(bfha_pkg::KIND_REQ,  4'hF, 16'h0001);  // nothing big enough
    send_word(bfha_pkg::KIND_LOAD, 4'hF, 16'hFFFF);
    send_word(bfha_pkg::KIND_LOAD, 4'h3, 16'd100);
    send_word(bfha_pkg::KIND_LOAD, 4'h5, 16'd100);
    send_word(bfha_pkg::KIND_REQ,  4'hA, 16'd50);    // tie between 3 and 5: lower wins
    send_word(bfha_pkg::KIND_REQ,  4'h5, 16'd100);
    send_word(bfha_pkg::KIND_REQ,  4'h0, 16'hFFFF);  // whole of the largest hole
    send_word(bfha_pkg::KIND_REQ,  4'h0, 16'h0001);
    send_word(bfha_pkg::KIND_LOAD, 4'h3, 16'h0000);  // reload frees a taken hole
    send_word(bfha_pkg::KIND_LOAD, 4'h0, 16'h0000);
    send_word(bfha_pkg::KIND_REQ,  4'hF, 16'h0000);
  endtask

  // Register extremes: small count, zero, above the table depth, one.
  task automatic test_count_limits();
    write_hole_count(5'd4);
    send_word(bfha_pkg::KIND_LOAD, 4'h4, 16'h1234);  // just past the holes in use
    send_word(bfha_pkg::KIND_LOAD, 4'h3, 16'h8000);
    send_word(bfha_pkg::KIND_REQ,  4'h0, 16'h8000);
    write_hole_count(5'd0);
    send_word(bfha_pkg::KIND_LOAD, 4'h0, 16'h0001);
    send_word(bfha_pkg::KIND_REQ,  4'h0, 16'h0000);
    write_hole_count(5'd31);               // saturates to the table depth
    send_word(bfha_pkg::KIND_LOAD, 4'hF, 16'h0007);
    send_word(bfha_pkg::KIND_REQ,  4'h0, 16'h0007);
    write_hole_count(5'd1);
    send_word(bfha_pkg::KIND_LOAD, 4'h0, 16'h0002);
    send_word(bfha_pkg::KIND_LOAD, 4'h1, 16'h0002);
    send_word(bfha_pkg::KIND_REQ,  4'h0, 16'h0000);
  endtask

  // Random loads and requests under one hole_count, with the odd full drain.
  task automatic test_random_mix(input logic [bfha_pkg::HCNT_W-1:0] count,
                                 input int unsigned n_words);
    int unsigned                 live;
    logic                        kind;
    logic [3:0]                  idx;
    logic [bfha_pkg::SIZE_W-1:0] amount;
    write_hole_count(count);
    live = live_holes();
    repeat (n_words) begin
      if ($urandom_range(99) < 45) begin
        kind   = bfha_pkg::KIND_LOAD;
        idx    = (live == 0 || $urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                       : 4'($urandom_range(live - 1));
        amount = load_amount();
      end else begin
        kind   = bfha_pkg::KIND_REQ;
        idx    = 4'($urandom);
        amount = request_amount();
      end
      send_word(kind, idx, amount);
      // hold the sender back until the block has caught up
      if ($urandom_range(149) == 0) wait_drain();
    end
  endtask

  // A long stretch with neither side idling.
  task automatic test_back_to_back();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    test_random_mix(5'd16, 200);
    wait_drain();
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  initial begin : result_check
    hole_outcome_t got;
    hole_outcome_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status         = out_ch.status;
        got.chosen_hole    = out_ch.chosen_hole;
        got.remaining_size = out_ch.remaining_size;
        if (due_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result word: status %0d hole %0d size %0d",
                     got.status, got.chosen_hole, got.remaining_size);
        end else begin
          want = due_outcomes.pop_front();
          if (got.status !== want.status || got.chosen_hole !== want.chosen_hole ||
              got.remaining_size !== want.remaining_size) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result mismatch: expected status %0d hole %0d size %0d, got %0d %0d %0d",
                       want.status, want.chosen_hole, want.remaining_size,
                       got.status, got.chosen_hole, got.remaining_size);
          end
        end
      end
      out_ch.ready <= !(recv_stalls && $urandom_range(99) < 19);
    end
  end

  // Hang detector: any word on either channel, or APB activity, restarts it.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("best_fit_hole_allocator regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int i;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = bfha_pkg::KIND_LOAD;
    in_ch.hole_index = '0;
    in_ch.amount     = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    mismatch_count   = 0;
    send_gaps        = 1'b1;
    recv_stalls      = 1'b1;
    hole_count_mirror = bfha_pkg::HCNT_RESET;
    for (i = 0; i < bfha_pkg::MAX_HOLES; i++) begin
      hole_size_mirror[i]  = '0;
      hole_taken_mirror[i] = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_fit();
    test_count_limits();
    test_random_mix(5'd16, 250);
    repeat (3) test_random_mix(bfha_pkg::HCNT_W'($urandom_range(2, 15)), 100);
    test_random_mix(5'd0, 30);
    test_random_mix(5'd1, 40);
    test_random_mix(5'd31, 100);
    test_random_mix(5'd17, 60);
    test_back_to_back();
    test_random_mix(5'd16, 250);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_outcomes.size() == 0)
      $display("best_fit_hole_allocator regression: pass");
    else
      $display("best_fit_hole_allocator regression: fail");
    $finish;
  end

endmodule
